[hdl/sifb_pkg.sv]
// shared constants and types for the interframe blend core
// no dependencies; used by the interfaces, the sequencer and the top level
package sifb_pkg;

  localparam int unsigned MAX_FRAME_PIXELS = 131072;
  localparam int unsigned PIXEL_W          = 32;
  localparam int unsigned DIM_W            = 9;
  localparam int unsigned PROD_W           = 19;

  localparam logic [PIXEL_W-1:0] BLEND_MASK = 32'h00fe_fefe;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd240;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd160;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] STORE_A = 2'd0;
  localparam logic [1:0] STORE_B = 2'd1;
  localparam logic [1:0] STORE_C = 2'd2;

  typedef logic [1:0] store_sel_t;

  typedef struct packed {
    store_sel_t one_back;
    store_sel_t two_back;
    store_sel_t three_back;
  } roles_t;

endpackage

[hdl/sifb_if.sv]
// valid/ready stream interfaces for the pixel input and output channels
// depends on sifb_pkg for the pixel width
interface sifb_pixel_in_if;
  logic                          valid;
  logic                          ready;
  logic [sifb_pkg::PIXEL_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sifb_pixel_out_if;
  logic                          valid;
  logic                          ready;
  logic [sifb_pkg::PIXEL_W-1:0]  pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

[hdl/sifb_store.sv]
// one frame store: synchronous ram with registered read and a fill count
// entries at or above the fill count read as zero; depends on nothing
module sifb_store #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_word;
  logic        rd_hit;
  logic [AW:0] fill;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // written entries always form a prefix, so one count tracks them
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= ({1'b0, rd_addr} < fill);
      end
      if (wr_en && ({1'b0, wr_addr} >= fill)) begin
        fill <= {1'b0, wr_addr} + 1'b1;
      end
    end
  end

  assign rd_data = rd_hit ? rd_word : '0;

endmodule

[hdl/sifb_seq.sv]
// raster position, store role rotation and frame size registers
// depends on sifb_pkg
module sifb_seq #(
  parameter int unsigned MAX_FRAME_PIXELS = sifb_pkg::MAX_FRAME_PIXELS,
  parameter int unsigned AW               = $clog2(MAX_FRAME_PIXELS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sifb_pkg::DIM_W-1:0]    cfg_data,
  input  logic                          step,
  output logic [AW-1:0]                 pos,
  output sifb_pkg::roles_t              roles
);

  localparam int unsigned CW = (AW + 1 > sifb_pkg::PROD_W) ? AW + 1 : sifb_pkg::PROD_W;

  logic [sifb_pkg::DIM_W-1:0]  frame_width;
  logic [sifb_pkg::DIM_W-1:0]  frame_height;
  logic [1:0]                  rotation;
  logic [1:0]                  rotation_next;
  logic [sifb_pkg::PROD_W-1:0] prod;
  logic [CW-1:0]               frame_len;
  logic [CW-1:0]               pos_inc;
  logic                        last;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sifb_pkg::WIDTH_RESET;
      frame_height <= sifb_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sifb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        sifb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    prod = (sifb_pkg::PROD_W'(frame_width) + sifb_pkg::PROD_W'(1))
           * sifb_pkg::PROD_W'(frame_height);
    frame_len = CW'(prod);
    if (frame_len == '0) begin
      frame_len = CW'(1);
    end else if (frame_len > CW'(MAX_FRAME_PIXELS)) begin
      frame_len = CW'(MAX_FRAME_PIXELS);
    end
    pos_inc = CW'(pos) + CW'(1);
    last    = (pos_inc >= frame_len);
  end

  always_comb begin
    case (rotation)
      2'd0:    rotation_next = 2'd1;
      2'd1:    rotation_next = 2'd2;
      default: rotation_next = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      rotation <= 2'd0;
    end else if (step) begin
      if (last) begin
        pos      <= '0;
        rotation <= rotation_next;
      end else begin
        pos <= pos_inc[AW-1:0];
      end
    end
  end

  always_comb begin
    case (rotation)
      2'd1: begin
        roles.one_back   = sifb_pkg::STORE_C;
        roles.two_back   = sifb_pkg::STORE_A;
        roles.three_back = sifb_pkg::STORE_B;
      end
      2'd2: begin
        roles.one_back   = sifb_pkg::STORE_B;
        roles.two_back   = sifb_pkg::STORE_C;
        roles.three_back = sifb_pkg::STORE_A;
      end
      default: begin
        roles.one_back   = sifb_pkg::STORE_A;
        roles.two_back   = sifb_pkg::STORE_B;
        roles.three_back = sifb_pkg::STORE_C;
      end
    endcase
  end

endmodule

[hdl/smart_interframe_blend_core.sv]
// channel    | dir | payload          | transfer
// video      | in  | pixel_in  [31:0] | valid && ready
// filtered   | out | pixel_out [31:0] | valid && ready
// cfg        | in  | cfg_index, cfg_data [8:0] | cfg_we
//
// one pixel per cycle while the output is not stalled; a pixel reaches the output through
// the registered read of the three frame stores followed by the blend stage
// writeback to the oldest store happens as the pixel leaves the blend stage, with
// forwarding when the next pixel reads the same entry
// reset needs no clearing pass: per-store fill counts make unwritten entries read as zero
// output stalls hold the output register; the blend stage still takes one more pixel
// depends on sifb_pkg, sifb_if, sifb_seq and sifb_store
module smart_interframe_blend_core #(
  parameter int unsigned MAX_FRAME_PIXELS = sifb_pkg::MAX_FRAME_PIXELS
) (
  input  logic                        clk,
  input  logic                        rst,
  sifb_pixel_in_if.sink               video,
  sifb_pixel_out_if.source            filtered,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sifb_pkg::DIM_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(MAX_FRAME_PIXELS);

  logic                          accept;
  logic                          advance;
  logic                          s1_fire;
  logic [AW-1:0]                 pos;
  sifb_pkg::roles_t              roles;

  logic                          s1_valid;
  logic [31:0]                   s1_cur;
  logic [AW-1:0]                 s1_pos;
  sifb_pkg::roles_t              s1_roles;
  logic                          fwd_hit;
  sifb_pkg::store_sel_t          fwd_store;
  logic [31:0]                   fwd_data;

  logic                          out_valid;
  logic [31:0]                   out_pixel;

  logic [31:0]                   rd_data [3];
  logic [31:0]                   word [3];
  logic [31:0]                   p1;
  logic [31:0]                   p2;
  logic [31:0]                   p3;
  logic                          blend;
  logic [31:0]                   res;

  assign advance      = !out_valid || filtered.ready;
  assign s1_fire      = s1_valid && advance;
  assign video.ready  = !s1_valid || advance;
  assign accept       = video.valid && video.ready;

  sifb_seq #(
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
    .AW(AW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .step(accept),
    .pos(pos),
    .roles(roles)
  );

  for (genvar k = 0; k < 3; k++) begin : g_store
    sifb_store #(
      .DEPTH(MAX_FRAME_PIXELS),
      .AW(AW)
    ) u_store (
      .clk(clk),
      .rst(rst),
      .rd_en(accept),
      .rd_addr(pos),
      .rd_data(rd_data[k]),
      .wr_en(s1_fire && (s1_roles.three_back == 2'(k))),
      .wr_addr(s1_pos),
      .wr_data(s1_cur)
    );

    assign word[k] = (fwd_hit && (fwd_store == 2'(k))) ? fwd_data : rd_data[k];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur    <= video.pixel_in;
      s1_pos    <= pos;
      s1_roles  <= roles;
      fwd_store <= s1_roles.three_back;
      fwd_data  <= s1_cur;
    end
    if (s1_fire) begin
      out_pixel <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        // the store read at this edge misses the writeback happening at the same edge
        fwd_hit  <= s1_fire && (s1_pos == pos);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    p1 = word[s1_roles.one_back];
    p2 = word[s1_roles.two_back];
    p3 = word[s1_roles.three_back];
    blend = (p1 != p2) && (p3 != s1_cur) && ((s1_cur == p2) || (p1 == p3));
    if (blend) begin
      res = ((s1_cur & sifb_pkg::BLEND_MASK) >> 1) + ((p1 & sifb_pkg::BLEND_MASK) >> 1);
    end else begin
      res = s1_cur;
    end
  end

  assign filtered.valid     = out_valid;
  assign filtered.pixel_out = out_pixel;

endmodule

[hdl/sifb_checker.sv]
// port-level checks for the interframe blend core, attached by bind
// depends on smart_interframe_blend_core and sifb_if
module sifb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped during a stall");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_pixel))
    else $error("output pixel changed during a stall");

  // input transfer is followed by a valid pixel in the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("transferred pixel did not reach the output");

  // input back-pressure only when the output is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output could drain");

endmodule

bind smart_interframe_blend_core sifb_checker u_sifb_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(video.valid),
  .in_ready(video.ready),
  .out_valid(filtered.valid),
  .out_ready(filtered.ready),
  .out_pixel(filtered.pixel_out)
);

[tb/tb_top.sv]
// self-checking testbench for smart_interframe_blend_core: pixel streams with flicker
// patterns, frame size writes between phases, random idling on both channels
// depends on sifb_pkg, sifb_if and the core rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [sifb_pkg::DIM_W-1:0] cfg_data;

  sifb_pixel_in_if  video_if ();
  sifb_pixel_out_if filtered_if ();

  smart_interframe_blend_core dut (
    .clk      (clk),
    .rst      (rst),
    .video    (video_if),
    .filtered (filtered_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // blend predictor state
  logic [sifb_pkg::PIXEL_W-1:0] store_words [int unsigned];
  int unsigned                  roll;
  int unsigned                  raster_pos;
  int unsigned                  cfg_width;
  int unsigned                  cfg_height;

  logic [sifb_pkg::PIXEL_W-1:0] pending_pixels [$];
  logic [sifb_pkg::PIXEL_W-1:0] expected_pixels [$];
  int unsigned                  queued_count;
  int unsigned                  accepted_count;
  int unsigned                  mismatch_count;
  int unsigned                  idle_cycles;
  int unsigned                  send_wait;
  int unsigned                  hold_cycles;
  bit                           video_took;
  bit                           quiet_phase;
  bit                           long_hold_req;

  function automatic logic [sifb_pkg::PIXEL_W-1:0] stored_word(int unsigned sel,
                                                               int unsigned pos);
    int unsigned key;
    key = sel * sifb_pkg::MAX_FRAME_PIXELS + pos;
    if (store_words.exists(key)) return store_words[key];
    return '0;
  endfunction

  function automatic logic [sifb_pkg::PIXEL_W-1:0] predict_pixel(
      logic [sifb_pkg::PIXEL_W-1:0] cur);
    int unsigned                  r;
    int unsigned                  three_sel;
    int unsigned                  pos;
    int unsigned                  len;
    logic [sifb_pkg::PIXEL_W-1:0] p1;
    logic [sifb_pkg::PIXEL_W-1:0] p2;
    logic [sifb_pkg::PIXEL_W-1:0] p3;
    logic [sifb_pkg::PIXEL_W-1:0] res;
    r = roll % 3;
    three_sel = (5 - r) % 3;
    pos = raster_pos % sifb_pkg::MAX_FRAME_PIXELS;
    p1 = stored_word((3 - r) % 3, pos);
    p2 = stored_word((4 - r) % 3, pos);
    p3 = stored_word(three_sel, pos);
    res = cur;
    if (p1 != p2 && p3 != cur && (cur == p2 || p1 == p3))
      res = ((cur & sifb_pkg::BLEND_MASK) >> 1) + ((p1 & sifb_pkg::BLEND_MASK) >> 1);
    store_words[three_sel * sifb_pkg::MAX_FRAME_PIXELS + pos] = cur;
    len = (cfg_width + 1) * cfg_height;
    if (len == 0) len = 1;
    if (len > sifb_pkg::MAX_FRAME_PIXELS) len = sifb_pkg::MAX_FRAME_PIXELS;
    if (pos + 1 >= len) begin
      raster_pos = 0;
      roll = (r + 1) % 3;
    end else begin
      raster_pos = pos + 1;
    end
    return res;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [sifb_pkg::PIXEL_W-1:0] got,
                                 logic [sifb_pkg::PIXEL_W-1:0] want);
    mismatch_count++;
    $display("%0t: %s: got %08h, expected %08h", $realtime, what, got, want);
  endtask

  task automatic queue_pixel(logic [sifb_pkg::PIXEL_W-1:0] value);
    pending_pixels.push_back(value);
    queued_count++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_pixels.size() != 0);
  endtask

  task automatic write_frame_size(int unsigned w, int unsigned h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sifb_pkg::REG_FRAME_WIDTH;
    cfg_data  <= sifb_pkg::DIM_W'(w);
    @(negedge clk);
    cfg_index <= sifb_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= sifb_pkg::DIM_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      video_if.valid <= 1'b0;
    end else if (!(video_if.valid && !video_took)) begin
      if (send_wait > 0) begin
        video_if.valid <= 1'b0;
        send_wait--;
      end else if (pending_pixels.size() != 0) begin
        video_if.pixel_in <= pending_pixels.pop_front();
        video_if.valid    <= 1'b1;
        send_wait = quiet_phase ? 0 : idle_gap();
      end else begin
        video_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      filtered_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      filtered_if.ready <= 1'b0;
      hold_cycles--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cycles = LONG_HOLD - 1;
      filtered_if.ready <= 1'b0;
    end else if (quiet_phase) begin
      filtered_if.ready <= 1'b1;
    end else begin
      hold_cycles = idle_gap();
      if (hold_cycles == 0) begin
        filtered_if.ready <= 1'b1;
      end else begin
        filtered_if.ready <= 1'b0;
        hold_cycles--;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin : monitor
    logic [sifb_pkg::PIXEL_W-1:0] want;
    bit                           out_took;
    if (rst) begin
      store_words.delete();
      roll        = 0;
      raster_pos  = 0;
      cfg_width   = sifb_pkg::WIDTH_RESET;
      cfg_height  = sifb_pkg::HEIGHT_RESET;
      video_took  = 1'b0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sifb_pkg::REG_FRAME_WIDTH) cfg_width = cfg_data;
        else cfg_height = cfg_data;
      end
      video_took = video_if.valid && video_if.ready;
      if (video_took) begin
        expected_pixels.push_back(predict_pixel(video_if.pixel_in));
        accepted_count++;
      end
      out_took = filtered_if.valid && filtered_if.ready;
      if (out_took) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel_out with no transfer pending", filtered_if.pixel_out, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (filtered_if.pixel_out !== want)
            report_mismatch("pixel_out", filtered_if.pixel_out, want);
        end
      end
      if (video_took || out_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [sifb_pkg::PIXEL_W-1:0] pal [3];
    int unsigned                  w;
    int unsigned                  h;
    int unsigned                  n;
    int unsigned                  pick;
    int unsigned                  phase;
    cfg_we            = 1'b0;
    cfg_index         = sifb_pkg::REG_FRAME_WIDTH;
    cfg_data          = '0;
    video_if.valid    = 1'b0;
    video_if.pixel_in = '0;
    filtered_if.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset frame size, fresh stores
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hffff_ffff);
    queue_pixel(32'haaaa_aaaa);
    queue_pixel(32'h5555_5555);
    queue_pixel(32'h00fe_fefe);
    queue_pixel(32'h0001_0101);
    wait_idle();

    // one-pixel frames, position already past the new length
    write_frame_size(0, 1);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hffff_ffff);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hffff_ffff);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'h1234_5678);
    queue_pixel(32'h9abc_def0);
    queue_pixel(32'h1234_5678);
    queue_pixel(32'h0f0f_0f0f);
    wait_idle();

    // zero height
    write_frame_size(511, 0);
    queue_pixel(32'h8000_0000);
    queue_pixel(32'h7fff_ffff);
    queue_pixel(32'h8000_0000);
    wait_idle();

    // frame length saturates
    write_frame_size(511, 511);
    queue_pixel(32'hdead_beef);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hffff_ffff);
    wait_idle();

    phase = 0;
    n = queued_count + RANDOM_ITEMS;
    while (queued_count < n) begin
      case (phase % 8)
        0: begin w = 511; h = 256; end
        3: begin w = 1;   h = 1;   end
        6: begin w = 0;   h = 0;   end
        default: begin
          w = $urandom_range(0, 7);
          h = $urandom_range(0, 5);
        end
      endcase
      write_frame_size(w, h);
      quiet_phase = (phase % 4 == 2);
      long_hold_req = (phase % 8 == 2);
      pal[0] = $urandom();
      pal[1] = $urandom();
      pal[2] = pal[0] ^ (32'h1 << $urandom_range(0, 31));
      repeat ((phase % 8 == 0) ? 60 : $urandom_range(120, 180)) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) queue_pixel(pal[0]);
        else if (pick < 80) queue_pixel(pal[1]);
        else if (pick < 92) queue_pixel(pal[2]);
        else queue_pixel($urandom());
      end
      wait_idle();
      quiet_phase = 1'b0;
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
